[hw/rtl/qrv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_pkg
// shared types for the quaternion vector rotation pipeline
// ----------------------------------------------------------------------------
package qrv_pkg;

	// control that travels with each request down the pipeline
	typedef struct packed {
		logic vld;
		logic zero;
	} ctrl_t;

endpackage

[hw/rtl/quaternion_rotate_vector.sv]
`timescale 1ns / 1ps
// throughput: one request per cycle, set by the fully pipelined matrix,
// product and bit-per-stage divider sections sharing one stall enable
// reset: arst_n clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// quaternion_rotate_vector
// rotates a body-frame vector to the world frame by a non-unit quaternion
// ----------------------------------------------------------------------------
module quaternion_rotate_vector #(
	parameter int VEC_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// body_x, body_y, body_z, quat_w, quat_x, quat_y, quat_z, zero fill
	input  logic [((3*VEC_WIDTH+4*QUAT_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// world_x, world_y, world_z, zero fill
	output logic [((3*VEC_WIDTH+7)/8)*8-1:0] m_tdata
);

	localparam int VW    = VEC_WIDTH;
	localparam int QW    = QUAT_WIDTH;
	localparam int OW    = ((3*VW+7)/8)*8;
	localparam int MW    = 2 * QW + 3;
	localparam int NUMW  = MW + VW + 3;
	localparam int QB    = VW + 1;

	logic                  en;
	qrv_pkg::ctrl_t        ctrl_in, ctrl_s2, ctrl_s4;
	logic signed [VW-1:0]  v_in [3];
	logic signed [VW-1:0]  v_s2 [3];
	logic signed [VW-1:0]  v_s4 [3];
	logic        [MW-2:0]  n2_s2;
	logic signed [MW-1:0]  m_s2 [9];
	logic        [MW-1:0]  den_s4;
	logic        [NUMW-1:0] num_s4 [3];
	logic                  neg_s4 [3];
	logic        [QB-1:0]  quo [3];

	qrv_pkg::ctrl_t        ctrl_d [QB];
	logic                  neg_d  [QB][3];
	logic signed [VW-1:0]  v_d    [QB][3];

	logic [VW-1:0] res [3];
	logic [VW-1:0] world_q [3];
	logic          vld_q;

	localparam logic [QB-1:0] HALF = QB'(1) << (VW - 1);

	// one enable for every stage: advance unless the result is held
	assign en       = !vld_q || m_tready;
	assign s_tready = en;

	assign ctrl_in.vld  = s_tvalid;
	assign ctrl_in.zero = 1'b0;
	assign v_in[0] = s_tdata[VW-1:0];
	assign v_in[1] = s_tdata[2*VW-1:VW];
	assign v_in[2] = s_tdata[3*VW-1:2*VW];

	qrv_matrix #(.VW(VW), .QW(QW)) u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_in  (ctrl_in),
		.v_in     (v_in),
		.qw       (s_tdata[3*VW+QW-1:3*VW]),
		.qx       (s_tdata[3*VW+2*QW-1:3*VW+QW]),
		.qy       (s_tdata[3*VW+3*QW-1:3*VW+2*QW]),
		.qz       (s_tdata[3*VW+4*QW-1:3*VW+3*QW]),
		.ctrl_out (ctrl_s2),
		.v_out    (v_s2),
		.n2       (n2_s2),
		.m        (m_s2)
	);

	qrv_product #(.VW(VW), .QW(QW)) u_product (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_in  (ctrl_s2),
		.v_in     (v_s2),
		.n2       (n2_s2),
		.m        (m_s2),
		.ctrl_out (ctrl_s4),
		.v_out    (v_s4),
		.den      (den_s4),
		.num      (num_s4),
		.neg      (neg_s4)
	);

	// one divider lane per output axis
	genvar k;
	generate
		for (k = 0; k < 3; k++) begin : g_lane
			qrv_divider #(.NUMW(NUMW), .DW(MW), .QB(QB)) u_divider (
				.clk (clk),
				.en  (en),
				.num (num_s4[k]),
				.den (den_s4),
				.quo (quo[k])
			);
		end
	endgenerate

	// control, sign and bypass vector alongside the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QB; i++) begin
				ctrl_d[i] <= '0;
			end
		end else if (en) begin
			ctrl_d[0] <= ctrl_s4;
			for (int i = 1; i < QB; i++) begin
				ctrl_d[i] <= ctrl_d[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_d[0] <= neg_s4;
			v_d[0]   <= v_s4;
			for (int i = 1; i < QB; i++) begin
				neg_d[i] <= neg_d[i-1];
				v_d[i]   <= v_d[i-1];
			end
		end
	end

	// saturate rounded quotient, or pass the vector for a zero quaternion
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (ctrl_d[QB-1].zero) begin
				res[j] = v_d[QB-1][j];
			end else if (neg_d[QB-1][j]) begin
				res[j] = (quo[j] > HALF) ? VW'(-HALF) : VW'(-quo[j]);
			end else begin
				res[j] = (quo[j] > HALF - QB'(1)) ? VW'(HALF - QB'(1)) : VW'(quo[j]);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= ctrl_d[QB-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			world_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = OW'({world_q[2], world_q[1], world_q[0]});

endmodule

[hw/rtl/qrv_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_matrix
// two stages: quaternion products, then unscaled rotation matrix and norm
// ----------------------------------------------------------------------------
module qrv_matrix #(
	parameter int VW = 32,
	parameter int QW = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  qrv_pkg::ctrl_t              ctrl_in,
	input  logic signed [VW-1:0]        v_in [3],
	input  logic signed [QW-1:0]        qw,
	input  logic signed [QW-1:0]        qx,
	input  logic signed [QW-1:0]        qy,
	input  logic signed [QW-1:0]        qz,
	output qrv_pkg::ctrl_t              ctrl_out,
	output logic signed [VW-1:0]        v_out [3],
	output logic        [2*QW+1:0]      n2,
	output logic signed [2*QW+2:0]      m [9]
);

	localparam int PW = 2 * QW;
	localparam int MW = 2 * QW + 3;

	qrv_pkg::ctrl_t        ctrl_s1;
	logic signed [VW-1:0]  v_s1 [3];
	logic signed [PW-1:0]  ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [MW-1:0]  e_ww, e_xx, e_yy, e_zz, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;
	logic signed [MW-1:0]  n2_full;

	// stage 1: the ten quaternion products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1  <= v_in;
			ww_s1 <= PW'(PW'(qw) * PW'(qw));
			xx_s1 <= PW'(PW'(qx) * PW'(qx));
			yy_s1 <= PW'(PW'(qy) * PW'(qy));
			zz_s1 <= PW'(PW'(qz) * PW'(qz));
			xy_s1 <= PW'(PW'(qx) * PW'(qy));
			wz_s1 <= PW'(PW'(qw) * PW'(qz));
			xz_s1 <= PW'(PW'(qx) * PW'(qz));
			wy_s1 <= PW'(PW'(qw) * PW'(qy));
			yz_s1 <= PW'(PW'(qy) * PW'(qz));
			wx_s1 <= PW'(PW'(qw) * PW'(qx));
		end
	end

	// sign extend products to matrix width
	assign e_ww = MW'(ww_s1);
	assign e_xx = MW'(xx_s1);
	assign e_yy = MW'(yy_s1);
	assign e_zz = MW'(zz_s1);
	assign e_xy = MW'(xy_s1);
	assign e_wz = MW'(wz_s1);
	assign e_xz = MW'(xz_s1);
	assign e_wy = MW'(wy_s1);
	assign e_yz = MW'(yz_s1);
	assign e_wx = MW'(wx_s1);
	assign n2_full = e_ww + e_xx + e_yy + e_zz;

	// stage 2: unscaled matrix terms and the squared norm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_out <= '0;
		end else if (en) begin
			ctrl_out.vld  <= ctrl_s1.vld;
			ctrl_out.zero <= (n2_full == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_out <= v_s1;
			n2    <= n2_full[MW-2:0];
			m[0]  <= (e_ww + e_xx) - (e_yy + e_zz);
			m[1]  <= (e_xy - e_wz) <<< 1;
			m[2]  <= (e_xz + e_wy) <<< 1;
			m[3]  <= (e_xy + e_wz) <<< 1;
			m[4]  <= (e_ww + e_yy) - (e_xx + e_zz);
			m[5]  <= (e_yz - e_wx) <<< 1;
			m[6]  <= (e_xz - e_wy) <<< 1;
			m[7]  <= (e_yz + e_wx) <<< 1;
			m[8]  <= (e_ww + e_zz) - (e_xx + e_yy);
		end
	end

endmodule

[hw/rtl/qrv_product.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_product
// two stages: matrix times vector products, then row sums and dividends
// ----------------------------------------------------------------------------
module qrv_product #(
	parameter int VW = 32,
	parameter int QW = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  qrv_pkg::ctrl_t                         ctrl_in,
	input  logic signed [VW-1:0]                   v_in [3],
	input  logic        [2*QW+1:0]                 n2,
	input  logic signed [2*QW+2:0]                 m [9],
	output qrv_pkg::ctrl_t                         ctrl_out,
	output logic signed [VW-1:0]                   v_out [3],
	output logic        [2*QW+2:0]                 den,
	output logic        [2*QW+VW+5:0]              num [3],
	output logic                                   neg [3]
);

	localparam int MW   = 2 * QW + 3;
	localparam int MVW  = MW + VW;
	localparam int SW   = MVW + 2;
	localparam int NUMW = SW + 1;

	qrv_pkg::ctrl_t        ctrl_s3;
	logic signed [VW-1:0]  v_s3 [3];
	logic        [MW-2:0]  n2_s3;
	logic signed [MVW-1:0] p_s3 [9];
	logic signed [SW-1:0]  sum [3];
	logic        [SW-1:0]  mag [3];

	// stage 3: nine products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s3 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s3  <= v_in;
			n2_s3 <= n2;
			for (int i = 0; i < 9; i++) begin
				p_s3[i] <= MVW'(m[i]) * MVW'(v_in[i % 3]);
			end
		end
	end

	// row sums and magnitude for the rounding divide
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = SW'(p_s3[3*k]) + SW'(p_s3[3*k+1]) + SW'(p_s3[3*k+2]);
			mag[k] = sum[k][SW-1] ? SW'(-sum[k]) : SW'(sum[k]);
		end
	end

	// stage 4: dividend 2|s| + n2 and divisor 2 n2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_out <= '0;
		end else if (en) begin
			ctrl_out <= ctrl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_out <= v_s3;
			den   <= {n2_s3, 1'b0};
			for (int k = 0; k < 3; k++) begin
				num[k] <= {mag[k], 1'b0} + NUMW'(n2_s3);
				neg[k] <= sum[k][SW-1];
			end
		end
	end

endmodule

[hw/rtl/qrv_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_divider
// restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module qrv_divider #(
	parameter int NUMW = 70,
	parameter int DW   = 35,
	parameter int QB   = 33
) (
	input  logic            clk,
	input  logic            en,
	input  logic [NUMW-1:0] num,
	input  logic [DW-1:0]   den,
	output logic [QB-1:0]   quo
);

	logic [DW:0]   rem_s [QB];
	logic [QB-1:0] lo_s  [QB];
	logic [QB-1:0] quo_s [QB];
	logic [DW-1:0] den_s [QB];

	genvar i;
	generate
		for (i = 0; i < QB; i++) begin : g_stage
			logic [DW:0]   rem_in;
			logic [QB-1:0] lo_in;
			logic [QB-1:0] quo_in;
			logic [DW-1:0] den_in;
			logic [DW:0]   trial;
			logic          ge;

			// first stage takes the upper dividend bits as partial remainder
			if (i == 0) begin : g_first
				assign rem_in = (DW+1)'(num >> QB);
				assign lo_in  = num[QB-1:0];
				assign quo_in = '0;
				assign den_in = den;
			end else begin : g_next
				assign rem_in = rem_s[i-1];
				assign lo_in  = lo_s[i-1];
				assign quo_in = quo_s[i-1];
				assign den_in = den_s[i-1];
			end

			// shift in next dividend bit, compare and subtract
			assign trial = {rem_in[DW-1:0], lo_in[QB-1]};
			assign ge    = (trial >= {1'b0, den_in});

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? (trial - {1'b0, den_in}) : trial;
					lo_s[i]  <= {lo_in[QB-2:0], 1'b0};
					quo_s[i] <= {quo_in[QB-2:0], ge};
					den_s[i] <= den_in;
				end
			end
		end
	endgenerate

	assign quo = quo_s[QB-1];

endmodule

[verif/quaternion_rotate_vector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_tb
// self-checking bench for the quaternion vector rotation pipeline: a short
// table of corner requests, then random requests under changing idle and
// stall patterns, each result checked against a typed value or an exact rational predictor
// ----------------------------------------------------------------------------
module quaternion_rotate_vector_tb;

	localparam int VEC_WIDTH   = 32;
	localparam int QUAT_WIDTH  = 16;
	localparam int WDOG_LIMIT  = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_PER_MODE = 225;

	localparam logic signed [31:0] VMAX = 32'sh7fffffff;
	localparam logic signed [31:0] VMIN = 32'sh80000000;
	localparam logic signed [15:0] Q_ONE = 16'sd16384;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// first field in the lowest bits
	typedef struct packed {
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_w;
		logic signed [31:0] body_z;
		logic signed [31:0] body_y;
		logic signed [31:0] body_x;
	} rot_req_t;

	typedef struct packed {
		logic signed [31:0] world_z;
		logic signed [31:0] world_y;
		logic signed [31:0] world_x;
	} world_vec_t;

	typedef struct {
		rot_req_t   req;
		logic       typed;
		world_vec_t result;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// body_x, body_y, body_z, quat_w, quat_x, quat_y, quat_z
	logic [159:0] s_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// world_x, world_y, world_z
	logic [95:0] m_tdata;

	world_vec_t world_queue[$];
	idle_mode_t idle_mode;
	logic hold_rx;
	int errors = 0;
	int quiet_cycles = 0;

	quaternion_rotate_vector #(
		.VEC_WIDTH (VEC_WIDTH),
		.QUAT_WIDTH(QUAT_WIDTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// round num/den to nearest, ties away from zero, clamp to 32 bits
	function automatic logic signed [31:0] div_round_clamp(logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0] mag;
		logic [127:0] d;
		logic [127:0] q;
		logic neg;
		neg = num < 0;
		mag = neg ? -num : num;
		d = den;
		q = ((mag << 1) + d) / (d << 1);
		if (neg) begin
			if (q > 128'h80000000) return VMIN;
			return -q[31:0];
		end
		if (q > 128'h7fffffff) return VMAX;
		return q[31:0];
	endfunction

	// world vector = M v / |q|^2 with M from the raw quaternion
	function automatic world_vec_t rotate_world(rot_req_t r);
		logic signed [127:0] w, x, y, z, n2, vx, vy, vz;
		logic signed [127:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
		world_vec_t o;
		w = $signed(r.quat_w);
		x = $signed(r.quat_x);
		y = $signed(r.quat_y);
		z = $signed(r.quat_z);
		vx = $signed(r.body_x);
		vy = $signed(r.body_y);
		vz = $signed(r.body_z);
		n2 = w*w + x*x + y*y + z*z;
		if (n2 == 0) begin
			o.world_x = r.body_x;
			o.world_y = r.body_y;
			o.world_z = r.body_z;
			return o;
		end
		m00 = w*w + x*x - y*y - z*z;
		m01 = 2 * (x*y - w*z);
		m02 = 2 * (x*z + w*y);
		m10 = 2 * (x*y + w*z);
		m11 = w*w + y*y - x*x - z*z;
		m12 = 2 * (y*z - w*x);
		m20 = 2 * (x*z - w*y);
		m21 = 2 * (y*z + w*x);
		m22 = w*w + z*z - x*x - y*y;
		o.world_x = div_round_clamp(m00*vx + m01*vy + m02*vz, n2);
		o.world_y = div_round_clamp(m10*vx + m11*vy + m12*vz, n2);
		o.world_z = div_round_clamp(m20*vx + m21*vy + m22*vz, n2);
		return o;
	endfunction

	function automatic int send_idle_pct();
		case (idle_mode)
			IDLE_SEND: return 46;
			IDLE_BOTH: return 6;
			default:   return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct();
		case (idle_mode)
			IDLE_RECV: return 46;
			IDLE_BOTH: return 6;
			default:   return 0;
		endcase
	endfunction

	// offer one request and wait for it to be taken
	task automatic offer_request(rot_req_t r, logic typed, world_vec_t typed_res);
		while ($urandom_range(99) < send_idle_pct()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= r;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		world_queue.push_back(typed ? typed_res : rotate_world(r));
	endtask

	function automatic logic signed [31:0] rand_body();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0: return VMAX;
					1: return VMIN;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			1: return $signed(32'($urandom_range(131071))) - 32'sd65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic rot_req_t rand_request();
		rot_req_t r;
		logic [31:0] a;
		logic [31:0] b;
		r.body_x = rand_body();
		r.body_y = rand_body();
		r.body_z = rand_body();
		a = $urandom;
		b = $urandom;
		{r.quat_w, r.quat_x} = a;
		{r.quat_y, r.quat_z} = b;
		case ($urandom_range(15)) inside
			0: {r.quat_w, r.quat_x, r.quat_y, r.quat_z} = '0;
			[1:2]: begin
				// tiny quaternions stress the normalisation
				r.quat_w = $signed(16'($urandom_range(6))) - 16'sd3;
				r.quat_x = $signed(16'($urandom_range(6))) - 16'sd3;
				r.quat_y = $signed(16'($urandom_range(6))) - 16'sd3;
				r.quat_z = $signed(16'($urandom_range(6))) - 16'sd3;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic rot_req_t mk_req(logic signed [31:0] bx, by, bz,
			logic signed [15:0] qw, qx, qy, qz);
		rot_req_t r;
		r.body_x = bx;
		r.body_y = by;
		r.body_z = bz;
		r.quat_w = qw;
		r.quat_x = qx;
		r.quat_y = qy;
		r.quat_z = qz;
		return r;
	endfunction

	// receiver ready pattern
	always @(posedge clk) begin
		if (hold_rx)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct());
	end

	// result checker
	always @(posedge clk) begin
		world_vec_t got;
		world_vec_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (world_queue.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				exp_res = world_queue.pop_front();
				if (got.world_x !== exp_res.world_x) begin
					$display("%0t world_x expected %h actual %h", $time,
						exp_res.world_x, got.world_x);
					errors++;
				end
				if (got.world_y !== exp_res.world_y) begin
					$display("%0t world_y expected %h actual %h", $time,
						exp_res.world_y, got.world_y);
					errors++;
				end
				if (got.world_z !== exp_res.world_z) begin
					$display("%0t world_z expected %h actual %h", $time,
						exp_res.world_z, got.world_z);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("FAIL quaternion_rotate_vector");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		table_row_t corners[$];
		world_vec_t none;
		int mode;
		int n;
		none = '0;
		idle_mode = IDLE_NONE;
		hold_rx = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;

		// zero quaternion passes the vector through
		corners.push_back('{mk_req(VMAX, VMIN, 32'sd0, 0, 0, 0, 0), 1'b1,
			'{32'sd0, VMIN, VMAX}});
		corners.push_back('{mk_req(-32'sd1, 32'sd1, VMIN, 0, 0, 0, 0), 1'b1,
			'{VMIN, 32'sd1, -32'sd1}});
		// identity rotations from scalar-only quaternions, including the extreme negative scalar
		corners.push_back('{mk_req(VMAX, VMIN, 32'sd65536, Q_ONE, 0, 0, 0), 1'b1,
			'{32'sd65536, VMIN, VMAX}});
		corners.push_back('{mk_req(VMIN, VMAX, -32'sd7, 16'sh8000, 0, 0, 0), 1'b1,
			'{-32'sd7, VMAX, VMIN}});
		corners.push_back('{mk_req(32'sd5, -32'sd9, 32'sd3, 16'sd1, 0, 0, 0), 1'b1,
			'{32'sd3, -32'sd9, 32'sd5}});
		// half turns about z and about x negate the other two axes, saturating the most negative
		corners.push_back('{mk_req(VMIN, VMAX, VMIN, 0, 0, 0, Q_ONE), 1'b1,
			'{VMIN, -VMAX, VMAX}});
		corners.push_back('{mk_req(VMIN, VMIN, 32'sd1, 0, 16'sh7fff, 0, 0), 1'b1,
			'{-32'sd1, VMAX, VMIN}});
		// remaining rows go through the predictor
		corners.push_back('{mk_req(VMAX, VMAX, VMAX, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh7fff), 1'b0, none});
		corners.push_back('{mk_req(VMIN, VMIN, VMIN, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000), 1'b0, none});
		corners.push_back('{mk_req(VMAX, VMIN, VMAX, 16'sh8000, 16'sh7fff,
			16'sh8000, 16'sh7fff), 1'b0, none});
		corners.push_back('{mk_req(VMAX, VMAX, 32'sd0, 16'sd11585, 0, 0, 16'sd11585),
			1'b0, none});
		corners.push_back('{mk_req(32'sd1, 32'sd1, 32'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1),
			1'b0, none});
		corners.push_back('{mk_req(32'sd3, -32'sd3, 32'sd1, 16'sd1, 16'sd1, 0, 0),
			1'b0, none});
		corners.push_back('{mk_req(-32'sd1, -32'sd1, -32'sd1, -16'sd1, 16'sd1, -16'sd1,
			16'sd1), 1'b0, none});
		corners.push_back('{mk_req(32'sd65536, 32'sd0, 32'sd0, 0, 16'sd1, 16'sd2,
			16'sd3), 1'b0, none});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		foreach (corners[i])
			offer_request(corners[i].req, corners[i].typed, corners[i].result);

		// random requests in each idle pattern
		for (mode = IDLE_NONE; mode <= IDLE_BOTH; mode++) begin
			idle_mode = idle_mode_t'(mode);
			if (mode == IDLE_NONE) begin
				// long receiver hold-off to fill the pipeline
				fork
					begin
						hold_rx <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_rx <= 1'b0;
					end
				join_none
			end
			for (n = 0; n < RAND_PER_MODE; n++)
				offer_request(rand_request(), 1'b0, none);
		end
		s_tvalid <= 1'b0;

		// drain, then run on with no traffic before the verdict
		while (world_queue.size() != 0) @(posedge clk);
		repeat (2 * (VEC_WIDTH + 6)) @(posedge clk);

		if (errors == 0 && world_queue.size() == 0) begin
			$display("PASS quaternion_rotate_vector");
		end else begin
			$display("FAIL quaternion_rotate_vector");
		end
		$finish;
	end

endmodule
